// ----- hw/rtl/sfq_pkg.sv -----
// Command and status codes for the searchable FIFO queue.
`default_nettype none

package sfq_pkg;

    localparam logic [2:0] CMD_PUSH   = 3'd0;
    localparam logic [2:0] CMD_MODIFY = 3'd1;
    localparam logic [2:0] CMD_SEARCH = 3'd2;
    localparam logic [2:0] CMD_POP    = 3'd3;
    localparam logic [2:0] CMD_COUNT  = 3'd4;
    localparam logic [2:0] CMD_MAX    = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/searchable_fifo_queue_core.sv -----
// Searchable FIFO queue: circular store with a scanning sequencer.
// Usage:
//   Input channel (in_valid / in_stall) carries one command item: cmd, key_value
//   and new_value. Output channel (out_valid / out_stall) returns exactly one
//   result item per command: status, data_out, position, occupancy.
//   Push, count, unused codes and any command on an empty queue (or push on a
//   full one) finish in the accept cycle; the result shows in the next cycle.
//   Pop reads the head slot: accept enters the scan state, the read of the head
//   slot is registered, then the result register loads. Search, modify and max
//   walk the stored entries from the head through the single read port of the
//   store, one entry per cycle. Search and modify stop at the first match.
//   in_stall is high while a scan runs and while an undelivered result is held
//   under out_stall, so one item is in flight at a time.
//   The result register holds its item for as long as out_stall is high.
//   Reset clears head, tail and count and drops any pending result; store
//   contents are not cleared and are only read after being written.
`default_nettype none

module searchable_fifo_queue_core #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire  [2:0]         cmd,
    input  wire  signed [31:0] key_value,
    input  wire  signed [31:0] new_value,
    output logic               out_valid,
    input  wire                out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] data_out,
    output logic [3:0]         position,
    output logic [4:0]         occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    logic signed [DATA_WIDTH-1:0] mem [DEPTH];

    sfq_pkg::state_t state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] issue_cnt_reg, issue_cnt_next;
    logic [CW-1:0] limit_reg, limit_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [AW-1:0] pend_off_reg, pend_off_next;
    logic [AW-1:0] pend_slot_reg, pend_slot_next;
    logic          out_valid_reg, out_valid_next;

    logic [2:0]                   cmd_reg, cmd_next;
    logic signed [DATA_WIDTH-1:0] key_reg, key_next;
    logic signed [DATA_WIDTH-1:0] nv_reg, nv_next;
    logic signed [DATA_WIDTH-1:0] best_reg, best_next;
    logic signed [DATA_WIDTH-1:0] rd_data_reg;

    logic [1:0]         status_reg;
    logic signed [31:0] data_reg;
    logic [3:0]         position_reg;
    logic [4:0]         occupancy_reg;

    logic                         accept;
    logic                         issue;
    logic                         hit;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic signed [DATA_WIDTH-1:0] wr_data;
    logic                         out_load;
    logic [1:0]                   out_status;
    logic signed [DATA_WIDTH-1:0] out_data;
    logic [AW-1:0]                out_pos;
    logic [CW-1:0]                out_occ;

    assign in_stall  = (state_reg != sfq_pkg::S_IDLE) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign issue     = (state_reg == sfq_pkg::S_SCAN) && (issue_cnt_reg != limit_reg);
    assign hit       = (rd_data_reg == key_reg);

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data_out  = data_reg;
    assign position  = position_reg;
    assign occupancy = occupancy_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        issue_cnt_next  = issue_cnt_reg;
        limit_next      = limit_reg;
        rd_ptr_next     = rd_ptr_reg;
        pend_valid_next = 1'b0;
        pend_off_next   = pend_off_reg;
        pend_slot_next  = pend_slot_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        nv_next         = nv_reg;
        best_next       = best_reg;
        wr_en           = 1'b0;
        wr_addr         = tail_reg;
        wr_data         = key_reg;
        out_load        = 1'b0;
        out_status      = sfq_pkg::ST_OK;
        out_data        = '0;
        out_pos         = '0;
        out_occ         = count_reg;

        unique case (state_reg)
            sfq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        sfq_pkg::CMD_PUSH:
                        begin
                            out_load = 1'b1;
                            if (count_reg == FULL_CNT)
                            begin
                                out_status = sfq_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = tail_reg;
                                wr_data    = DATA_WIDTH'(key_value);
                                tail_next  = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
                                count_next = count_reg + 1'b1;
                                out_occ    = count_next;
                            end
                        end
                        sfq_pkg::CMD_MODIFY, sfq_pkg::CMD_SEARCH,
                        sfq_pkg::CMD_POP, sfq_pkg::CMD_MAX:
                        begin
                            if (count_reg == '0)
                            begin
                                out_load   = 1'b1;
                                out_status = sfq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next     = sfq_pkg::S_SCAN;
                                cmd_next       = cmd;
                                key_next       = DATA_WIDTH'(key_value);
                                nv_next        = DATA_WIDTH'(new_value);
                                limit_next     = (cmd == sfq_pkg::CMD_POP) ? CW'(1) : count_reg;
                                issue_cnt_next = '0;
                                rd_ptr_next    = head_reg;
                            end
                        end
                        default:
                        begin
                            // count and unused codes
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            sfq_pkg::S_SCAN:
            begin
                if (issue)
                begin
                    rd_ptr_next     = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
                    issue_cnt_next  = issue_cnt_reg + 1'b1;
                    pend_valid_next = 1'b1;
                    pend_off_next   = issue_cnt_reg[AW-1:0];
                    pend_slot_next  = rd_ptr_reg;
                end
                if (pend_valid_reg)
                begin
                    case (cmd_reg)
                        sfq_pkg::CMD_POP:
                        begin
                            out_load   = 1'b1;
                            out_data   = rd_data_reg;
                            head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                            count_next = count_reg - 1'b1;
                            out_occ    = count_next;
                            state_next = sfq_pkg::S_IDLE;
                        end
                        sfq_pkg::CMD_MAX:
                        begin
                            if (pend_off_reg == '0 || rd_data_reg > best_reg)
                            begin
                                best_next = rd_data_reg;
                            end
                            if (!issue)
                            begin
                                out_load   = 1'b1;
                                out_data   = best_next;
                                state_next = sfq_pkg::S_IDLE;
                            end
                        end
                        default:
                        begin
                            // search and modify: stop at first match
                            if (hit)
                            begin
                                out_load   = 1'b1;
                                out_pos    = pend_off_reg;
                                state_next = sfq_pkg::S_IDLE;
                                if (cmd_reg == sfq_pkg::CMD_MODIFY)
                                begin
                                    out_data = rd_data_reg;
                                    wr_en    = 1'b1;
                                    wr_addr  = pend_slot_reg;
                                    wr_data  = nv_reg;
                                end
                            end
                            else if (!issue)
                            begin
                                out_load   = 1'b1;
                                out_status = sfq_pkg::ST_NOT_FOUND;
                                state_next = sfq_pkg::S_IDLE;
                            end
                        end
                    endcase
                    if (state_next == sfq_pkg::S_IDLE)
                    begin
                        pend_valid_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = sfq_pkg::S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sfq_pkg::S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            issue_cnt_reg  <= '0;
            limit_reg      <= '0;
            rd_ptr_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            issue_cnt_reg  <= issue_cnt_next;
            limit_reg      <= limit_next;
            rd_ptr_reg     <= rd_ptr_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_off_reg  <= pend_off_next;
        pend_slot_reg <= pend_slot_next;
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        nv_reg        <= nv_next;
        best_reg      <= best_next;
        if (out_load)
        begin
            status_reg    <= out_status;
            data_reg      <= 32'(out_data);
            position_reg  <= 4'(out_pos);
            occupancy_reg <= 5'(out_occ);
        end
    end

    // single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

endmodule

`default_nettype wire
